[rtl/mcngs_pkg.sv]
// Package for the mixture copy-number grid scorer.
// Beat types, widths, operation and register codes, sequencer states.
// No dependencies.
package mcngs_pkg;

  localparam int MAX_COPY = 7;
  localparam int ROW_W    = 3;
  localparam int ADDR_W   = 2 * ROW_W;
  localparam int DEPTH    = 1 << ADDR_W;

  localparam int CW       = 10;
  localparam int XW       = 30;
  localparam int PRIOR_W  = 32;
  localparam int SCORE_W  = 40;
  localparam int QW       = 48;
  localparam int DW       = 20;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 64;
  localparam int TOT_W    = 50;

  localparam int DIV_STEP  = 4;
  localparam int DIV_ITER  = QW / DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  localparam logic [SCORE_W-1:0] SENTINEL  = SCORE_W'(64'd999999 << 16);
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [DW-1:0]      RATIO_DEN = DW'(80);
  localparam logic [PROD_W-1:0]  RATIO_RND = PROD_W'(40 * 65536);

  typedef enum logic [1:0] {
    OP_LOAD_FWD = 2'd0,
    OP_LOAD_REV = 2'd1,
    OP_EVAL     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_RATIO_SCALE = 2'd0,
    REG_ALLELE_CAP  = 2'd1,
    REG_COPY_LIMIT  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]                operation;
    logic [6:0]                normal_step;
    logic [5:0]                tumor_step;
    logic [ROW_W-1:0]          prior_row;
    logic [ROW_W-1:0]          prior_col;
    logic signed [PRIOR_W-1:0] prior_value;
    logic [19:0]               ratio_linear;
    logic [16:0]               allele_fraction;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] best_score;
    logic [2:0]         copy_second;
    logic [2:0]         copy_first;
    logic [2:0]         allele_second;
    logic [2:0]         allele_first;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAIR_C2,
    S_PAIR_CS,
    S_PAIR_DIFF,
    S_PAIR_SQ,
    S_PAIR_LOAD,
    S_PAIR_DIV,
    S_CAND_FC,
    S_CAND_DIFF,
    S_CAND_SQ,
    S_CAND_SCALE,
    S_CAND_LOAD,
    S_CAND_DIV,
    S_CAND_CMP,
    S_FINISH,
    S_DONE
  } state_t;

endpackage

[rtl/mcngs_div.sv]
// Iterative unsigned divider, DIV_STEP quotient bits per cycle.
// Depends on mcngs_pkg for widths and iteration count.
module mcngs_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [mcngs_pkg::QW-1:0] dividend,
  input  logic [mcngs_pkg::DW-1:0] divisor,
  output logic                    busy,
  output logic [mcngs_pkg::QW-1:0] quotient
);

  logic [mcngs_pkg::QW-1:0]        quo_r, quo_nxt;
  logic [mcngs_pkg::DW-1:0]        rem_r, rem_nxt;
  logic [mcngs_pkg::DW-1:0]        div_r;
  logic [mcngs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                            busy_r;

  always_comb begin
    logic [mcngs_pkg::DW:0] rem_t;
    logic [mcngs_pkg::QW-1:0] quo_t;
    rem_t = {1'b0, rem_r};
    quo_t = quo_r;
    for (int i = 0; i < mcngs_pkg::DIV_STEP; i++) begin
      rem_t = {rem_t[mcngs_pkg::DW-1:0], quo_t[mcngs_pkg::QW-1]};
      quo_t = {quo_t[mcngs_pkg::QW-2:0], 1'b0};
      if (rem_t >= {1'b0, div_r}) begin
        rem_t    = rem_t - {1'b0, div_r};
        quo_t[0] = 1'b1;
      end
    end
    rem_nxt = rem_t[mcngs_pkg::DW-1:0];
    quo_nxt = quo_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == mcngs_pkg::DIV_CNT_W'(mcngs_pkg::DIV_ITER - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

[rtl/mixture_copy_number_grid_score.sv]
// Top level of the mixture copy-number grid scorer.
// Depends on mcngs_pkg and on the shared divider mcngs_div.
//
// The block scores one point of a normal / tumor-one / tumor-two mixture
// grid. Load beats (operation 0 and 1) write one signed Q16.16 log prior
// into the forward or reverse table and return one all-zero result beat.
// An evaluate beat (operation 2) searches every pair of tumor copy numbers
// up to copy_limit and, inside each pair, every allele split up to
// allele_cap, and returns the smallest squared-error score plus priors with
// the winning copy numbers and allele counts. Points off the grid triangle
// return the sentinel 999999 in Q24.16.
// A single 32 by 32 multiplier and a single divider that retires four
// quotient bits per cycle are shared by all terms under a small sequencer.
// Each copy pair first sets up its ratio term, including a division by 80,
// and each allele split then forms its allele term, including a division
// by the squared expected copy number. With both limits at 7 an evaluate
// covers 64 copy pairs and 1296 allele splits.
// The input is stalled for the whole search. The result sits in an output
// register, so a finished beat waits there without holding up the next one.
// Prior entries that were never written read back as arbitrary values.
module mixture_copy_number_grid_score (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mcngs_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mcngs_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [19:0]          cfg_data
);

  // Configuration registers.
  logic [19:0] ratio_scale_r;
  logic [2:0]  allele_cap_r;
  logic [2:0]  copy_limit_r;

  mcngs_pkg::state_t state_r, state_nxt;

  // Latched grid point and observations.
  logic [6:0]  ns_r;
  logic [6:0]  ts_r;
  logic [6:0]  us_r;
  logic [19:0] rl_r;
  logic [16:0] af_r;

  // Search indices and incremental sums of hundredths.
  logic [mcngs_pkg::ROW_W-1:0] r1_r, r2_r, a_r, b_r;
  logic [mcngs_pkg::CW-1:0]    c_row_r, c_r, p_row_r, p_r;

  logic [mcngs_pkg::DW-1:0]     c2_r;
  logic [mcngs_pkg::XW-1:0]     x_r;
  logic [mcngs_pkg::PROD_W-1:0] mul_p_r;
  logic [mcngs_pkg::PROD_W-1:0] n500_r;
  logic [mcngs_pkg::QW-1:0]     ratio_r;
  logic signed [mcngs_pkg::TOT_W-1:0] tot_r;
  logic signed [mcngs_pkg::PRIOR_W:0] prs_r;
  logic signed [mcngs_pkg::TOT_W-1:0] best_r;
  logic [mcngs_pkg::ROW_W-1:0] best_r1_r, best_r2_r, best_a_r, best_b_r;
  logic        have_r;

  // Prior tables.
  logic signed [mcngs_pkg::PRIOR_W-1:0] fwd_mem [mcngs_pkg::DEPTH];
  logic signed [mcngs_pkg::PRIOR_W-1:0] rev_mem [mcngs_pkg::DEPTH];
  logic signed [mcngs_pkg::PRIOR_W-1:0] fwd_q_r, rev_q_r;

  logic                 out_valid_r;
  mcngs_pkg::out_item_t res_r;
  mcngs_pkg::out_item_t out_data_r;

  logic in_accept;
  logic out_take;
  logic [mcngs_pkg::ROW_W-1:0] lim, ca, cb;
  logic [mcngs_pkg::ADDR_W-1:0] fwd_addr, rev_addr;
  logic [mcngs_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic                         div_start, div_busy;
  logic [mcngs_pkg::QW-1:0]     div_dividend, div_quotient;
  logic [mcngs_pkg::DW-1:0]     div_divisor;
  logic signed [mcngs_pkg::TOT_W-1:0] cand_total;
  logic off_grid;
  logic [7:0] ts_max;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != mcngs_pkg::S_IDLE);
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lim = (copy_limit_r > 3'(mcngs_pkg::MAX_COPY)) ? 3'(mcngs_pkg::MAX_COPY)
                                                         : copy_limit_r;
  assign ca  = (r1_r > allele_cap_r) ? allele_cap_r : r1_r;
  assign cb  = (r2_r > allele_cap_r) ? allele_cap_r : r2_r;

  assign fwd_addr = {a_r, b_r};
  assign rev_addr = {lim - ca + a_r, lim - cb + b_r};

  // The grid triangle: tumor-one share may not exceed half of what the
  // normal share leaves, with the usual integer rounding.
  assign ts_max   = (8'd101 - {1'b0, in_data.normal_step}) >> 1;
  assign off_grid = (in_data.normal_step > 7'd99) ||
                    ({2'b0, in_data.tumor_step} > ts_max);

  assign cand_total = tot_r + mcngs_pkg::TOT_W'(prs_r);

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_scale_r <= 20'd65536;
      allele_cap_r  <= 3'd7;
      copy_limit_r  <= 3'd7;
    end else if (cfg_we) begin
      unique case (mcngs_pkg::reg_idx_t'(cfg_index))
        mcngs_pkg::REG_RATIO_SCALE: ratio_scale_r <= cfg_data;
        mcngs_pkg::REG_ALLELE_CAP:  allele_cap_r  <= cfg_data[2:0];
        mcngs_pkg::REG_COPY_LIMIT:  copy_limit_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Prior tables: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (in_accept && in_data.operation == mcngs_pkg::OP_LOAD_FWD) begin
      fwd_mem[{in_data.prior_row, in_data.prior_col}] <= in_data.prior_value;
    end
    if (in_accept && in_data.operation == mcngs_pkg::OP_LOAD_REV) begin
      rev_mem[{in_data.prior_row, in_data.prior_col}] <= in_data.prior_value;
    end
    fwd_q_r <= fwd_mem[fwd_addr];
    rev_q_r <= rev_mem[rev_addr];
  end

  // Shared multiplier, operands chosen by the sequencer.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      mcngs_pkg::S_PAIR_C2: begin
        mul_a = mcngs_pkg::MUL_W'(c_r);
        mul_b = mcngs_pkg::MUL_W'(c_r);
      end
      mcngs_pkg::S_PAIR_CS: begin
        mul_a = mcngs_pkg::MUL_W'(c_r);
        mul_b = mcngs_pkg::MUL_W'(ratio_scale_r);
      end
      mcngs_pkg::S_CAND_FC: begin
        mul_a = mcngs_pkg::MUL_W'(af_r);
        mul_b = mcngs_pkg::MUL_W'(c_r);
      end
      mcngs_pkg::S_PAIR_SQ, mcngs_pkg::S_CAND_SQ: begin
        mul_a = mcngs_pkg::MUL_W'(x_r);
        mul_b = mcngs_pkg::MUL_W'(x_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // Shared divider: the ratio term divides by 80, the allele term by C^2
  // (or by one when the expected copy number is zero).
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = mcngs_pkg::RATIO_DEN;
    if (state_r == mcngs_pkg::S_PAIR_LOAD) begin
      div_start    = 1'b1;
      div_dividend = mcngs_pkg::QW'((mul_p_r + mcngs_pkg::RATIO_RND) >> 16);
    end else if (state_r == mcngs_pkg::S_CAND_LOAD) begin
      div_start    = 1'b1;
      div_dividend = mcngs_pkg::QW'(
          (n500_r + (mcngs_pkg::PROD_W'(c2_r) << 15)) >> 16);
      div_divisor  = c2_r;
    end
  end

  mcngs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcngs_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_data.operation == mcngs_pkg::OP_EVAL && !off_grid) begin
            state_nxt = mcngs_pkg::S_PAIR_C2;
          end else begin
            state_nxt = mcngs_pkg::S_DONE;
          end
        end
      end
      mcngs_pkg::S_PAIR_C2:    state_nxt = mcngs_pkg::S_PAIR_CS;
      mcngs_pkg::S_PAIR_CS:    state_nxt = mcngs_pkg::S_PAIR_DIFF;
      mcngs_pkg::S_PAIR_DIFF:  state_nxt = mcngs_pkg::S_PAIR_SQ;
      mcngs_pkg::S_PAIR_SQ:    state_nxt = mcngs_pkg::S_PAIR_LOAD;
      mcngs_pkg::S_PAIR_LOAD:  state_nxt = mcngs_pkg::S_PAIR_DIV;
      mcngs_pkg::S_PAIR_DIV: begin
        if (!div_busy) state_nxt = mcngs_pkg::S_CAND_FC;
      end
      mcngs_pkg::S_CAND_FC:    state_nxt = mcngs_pkg::S_CAND_DIFF;
      mcngs_pkg::S_CAND_DIFF:  state_nxt = mcngs_pkg::S_CAND_SQ;
      mcngs_pkg::S_CAND_SQ:    state_nxt = mcngs_pkg::S_CAND_SCALE;
      mcngs_pkg::S_CAND_SCALE: state_nxt = mcngs_pkg::S_CAND_LOAD;
      mcngs_pkg::S_CAND_LOAD:  state_nxt = mcngs_pkg::S_CAND_DIV;
      mcngs_pkg::S_CAND_DIV: begin
        if (!div_busy) state_nxt = mcngs_pkg::S_CAND_CMP;
      end
      mcngs_pkg::S_CAND_CMP: begin
        if (a_r != ca || b_r != cb) begin
          state_nxt = mcngs_pkg::S_CAND_FC;
        end else if (r1_r != lim || r2_r != lim) begin
          state_nxt = mcngs_pkg::S_PAIR_C2;
        end else begin
          state_nxt = mcngs_pkg::S_FINISH;
        end
      end
      mcngs_pkg::S_FINISH:     state_nxt = mcngs_pkg::S_DONE;
      mcngs_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = mcngs_pkg::S_IDLE;
      end
      default:                 state_nxt = mcngs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcngs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers, advanced by the sequencer.
  always_ff @(posedge clk) begin
    logic signed [31:0] rdiff;
    logic signed [29:0] adiff;
    logic [mcngs_pkg::SCORE_W-1:0] sat_score;
    rdiff = 32'sd0;
    adiff = 30'sd0;
    sat_score = '0;
    case (state_r)
      mcngs_pkg::S_IDLE: begin
        if (in_accept && in_data.operation == mcngs_pkg::OP_EVAL && off_grid) begin
          res_r <= '{best_score: mcngs_pkg::SENTINEL, default: '0};
        end else begin
          res_r <= '0;
        end
        if (in_accept && in_data.operation == mcngs_pkg::OP_EVAL) begin
          ns_r    <= in_data.normal_step;
          ts_r    <= {1'b0, in_data.tumor_step};
          us_r    <= 7'd100 - in_data.normal_step - {1'b0, in_data.tumor_step};
          rl_r    <= in_data.ratio_linear;
          af_r    <= in_data.allele_fraction;
          r1_r    <= '0;
          r2_r    <= '0;
          a_r     <= '0;
          b_r     <= '0;
          c_row_r <= mcngs_pkg::CW'({in_data.normal_step, 1'b0});
          c_r     <= mcngs_pkg::CW'({in_data.normal_step, 1'b0});
          p_row_r <= mcngs_pkg::CW'(in_data.normal_step);
          p_r     <= mcngs_pkg::CW'(in_data.normal_step);
        end
      end
      mcngs_pkg::S_PAIR_CS: begin
        c2_r <= (c_r == '0) ? mcngs_pkg::DW'(1) : mul_p_r[mcngs_pkg::DW-1:0];
      end
      mcngs_pkg::S_PAIR_DIFF: begin
        // 200*R minus C*scale, kept as a magnitude for squaring.
        rdiff = $signed({4'b0, rl_r, 8'b0} - {6'b0, rl_r, 6'b0} +
                        {9'b0, rl_r, 3'b0}) - $signed(mul_p_r[31:0]);
        x_r <= mcngs_pkg::XW'(rdiff[31] ? -rdiff : rdiff);
      end
      mcngs_pkg::S_PAIR_DIV: begin
        if (!div_busy) ratio_r <= div_quotient;
      end
      mcngs_pkg::S_CAND_DIFF: begin
        // With C at zero the fraction is repaired to zero: the term is F^2.
        adiff = $signed({4'b0, p_r, 16'b0}) - $signed({2'b0, mul_p_r[27:0]});
        if (c_r == '0) begin
          x_r <= mcngs_pkg::XW'(af_r);
        end else begin
          x_r <= mcngs_pkg::XW'(adiff[29] ? -adiff : adiff);
        end
        prs_r <= 33'(fwd_q_r) + 33'(rev_q_r);
      end
      mcngs_pkg::S_CAND_SCALE: begin
        n500_r <= (mul_p_r << 9) - (mul_p_r << 3) - (mul_p_r << 2);
      end
      mcngs_pkg::S_CAND_DIV: begin
        if (!div_busy) begin
          tot_r <= $signed(mcngs_pkg::TOT_W'(ratio_r) + mcngs_pkg::TOT_W'(div_quotient));
        end
      end
      mcngs_pkg::S_CAND_CMP: begin
        if (!have_r || cand_total < best_r) begin
          best_r    <= cand_total;
          best_r1_r <= r1_r;
          best_r2_r <= r2_r;
          best_a_r  <= a_r;
          best_b_r  <= b_r;
        end
        if (a_r != ca) begin
          a_r <= a_r + 1'b1;
          p_r <= p_r + mcngs_pkg::CW'(ts_r);
        end else if (b_r != cb) begin
          a_r     <= '0;
          b_r     <= b_r + 1'b1;
          p_row_r <= p_row_r + mcngs_pkg::CW'(us_r);
          p_r     <= p_row_r + mcngs_pkg::CW'(us_r);
        end else begin
          a_r     <= '0;
          b_r     <= '0;
          p_row_r <= mcngs_pkg::CW'(ns_r);
          p_r     <= mcngs_pkg::CW'(ns_r);
          if (r1_r != lim) begin
            r1_r <= r1_r + 1'b1;
            c_r  <= c_r + mcngs_pkg::CW'(ts_r);
          end else if (r2_r != lim) begin
            r1_r    <= '0;
            r2_r    <= r2_r + 1'b1;
            c_row_r <= c_row_r + mcngs_pkg::CW'(us_r);
            c_r     <= c_row_r + mcngs_pkg::CW'(us_r);
          end
        end
      end
      mcngs_pkg::S_FINISH: begin
        if (best_r < 0) begin
          sat_score = '0;
        end else if (best_r > $signed(mcngs_pkg::TOT_W'(mcngs_pkg::SCORE_MAX))) begin
          sat_score = mcngs_pkg::SCORE_MAX;
        end else begin
          sat_score = best_r[mcngs_pkg::SCORE_W-1:0];
        end
        res_r <= '{best_score: sat_score, copy_second: best_r2_r, copy_first: best_r1_r,
                   allele_second: best_b_r, allele_first: best_a_r};
      end
      default: ;
    endcase
  end

  // First candidate of a search always wins; later ones only if smaller.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (state_r == mcngs_pkg::S_IDLE) begin
      have_r <= 1'b0;
    end else if (state_r == mcngs_pkg::S_CAND_CMP) begin
      have_r <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == mcngs_pkg::S_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mcngs_pkg::S_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r <= res_r;
    end
  end

`ifndef SYNTHESIS
  // An accepted beat always starts work, so the input stalls next cycle.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // The divider is never restarted while it is still working.
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // Allele indices never run past the caps of the current copy pair.
  a_allele_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcngs_pkg::S_CAND_CMP) |-> (a_r <= ca && b_r <= cb))
    else $error("allele index beyond cap");
`endif

endmodule

[tb/mixture_copy_number_grid_score_tb.sv]
// Self-checking testbench for mixture_copy_number_grid_score.
// Depends on mcngs_pkg and the RTL top level; a queue-fed driver, a monitor and a
// scoreboard checked against a built-in predictor of the grid search.
module mixture_copy_number_grid_score_tb;

  localparam int IN_W = $bits(mcngs_pkg::in_item_t);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  mcngs_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  mcngs_pkg::out_item_t out_data;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [19:0]          cfg_data = '0;

  mixture_copy_number_grid_score dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copies of the register file and the two prior tables.
  longint unsigned scale_shadow = 65536;
  int              cap_shadow   = 7;
  int              limit_shadow = 7;
  longint          fwd_prior_tab [mcngs_pkg::DEPTH];
  longint          rev_prior_tab [mcngs_pkg::DEPTH];

  mcngs_pkg::in_item_t  pending_beats [$];
  mcngs_pkg::out_item_t expected_scores [$];
  int                   failures = 0;

  // Handshake bookkeeping, set at the rising edge and used at the falling edge.
  bit in_took, out_took;
  int send_gap = 0, recv_gap = 0;
  bit send_busy = 1'b0, recv_busy = 1'b0;
  bit hold_req = 1'b0, hold_done = 1'b0;
  int hold_cnt = 0;

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint unsigned square_mag(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    return m * m;
  endfunction

  // Applies one input beat to the shadow state and returns the result beat it causes.
  function automatic mcngs_pkg::out_item_t score_point(mcngs_pkg::in_item_t it);
    mcngs_pkg::out_item_t res;
    longint ns, ts, us, rr, ff, cc, pp, lim, ca, cb, ratio_term, term, total, best, lb;
    int r1, r2, a, b, la, lbb;
    bit have, hv;
    res = '0;
    case (mcngs_pkg::op_t'(it.operation))
      mcngs_pkg::OP_LOAD_FWD: fwd_prior_tab[{it.prior_row, it.prior_col}] =
                                longint'(it.prior_value);
      mcngs_pkg::OP_LOAD_REV: rev_prior_tab[{it.prior_row, it.prior_col}] =
                                longint'(it.prior_value);
      mcngs_pkg::OP_NONE: ;
      mcngs_pkg::OP_EVAL: begin
        ns = it.normal_step;
        ts = it.tumor_step;
        if (ns > 99 || ts > (101 - ns) / 2) begin
          res.best_score = mcngs_pkg::SENTINEL;
        end else begin
          us = 100 - ns - ts;
          rr = it.ratio_linear;
          ff = it.allele_fraction;
          lim = (limit_shadow < mcngs_pkg::MAX_COPY) ? limit_shadow : mcngs_pkg::MAX_COPY;
          have = 1'b0;
          best = 0;
          for (r2 = 0; r2 <= lim; r2++) begin
            for (r1 = 0; r1 <= lim; r1++) begin
              cc = 2 * ns + r1 * ts + r2 * us;
              ca = (r1 > cap_shadow) ? cap_shadow : r1;
              cb = (r2 > cap_shadow) ? cap_shadow : r2;
              ratio_term = round_div(square_mag(200 * rr - cc * longint'(scale_shadow)),
                                     80 * 65536);
              hv = 1'b0;
              lb = 0;
              la = 0;
              lbb = 0;
              // Allele splits: b outer, a inner; only a strictly smaller score wins.
              for (b = 0; b <= cb; b++) begin
                for (a = 0; a <= ca; a++) begin
                  if (cc == 0) begin
                    // The 0/0 fraction is taken as zero.
                    term = round_div(500 * square_mag(ff), 65536);
                  end else begin
                    pp = ns + a * ts + b * us;
                    term = round_div(500 * square_mag(65536 * pp - ff * cc),
                                     65536 * cc * cc);
                  end
                  term += fwd_prior_tab[a * (mcngs_pkg::MAX_COPY + 1) + b]
                        + rev_prior_tab[(lim - ca + a) * (mcngs_pkg::MAX_COPY + 1)
                                        + (lim - cb + b)];
                  if (!hv || term < lb) begin
                    hv = 1'b1; lb = term; la = a; lbb = b;
                  end
                end
              end
              total = ratio_term + lb;
              if (!have || total < best) begin
                have = 1'b1;
                best = total;
                res.copy_first = 3'(r1);
                res.copy_second = 3'(r2);
                res.allele_first = 3'(la);
                res.allele_second = 3'(lbb);
              end
            end
          end
          if (best < 0) res.best_score = '0;
          else if (best > longint'(mcngs_pkg::SCORE_MAX)) res.best_score = mcngs_pkg::SCORE_MAX;
          else res.best_score = mcngs_pkg::SCORE_W'(best);
        end
      end
    endcase
    return res;
  endfunction

  // Rising edge: note accepted beats, predict on the input side, check on the output side.
  always @(posedge clk) begin
    in_took = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;
    if (in_took) expected_scores.push_back(score_point(in_data));
    if (out_took) begin
      if (expected_scores.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_data);
        failures++;
      end else begin
        mcngs_pkg::out_item_t want;
        want = expected_scores.pop_front();
        if (want.best_score !== out_data.best_score)
          $display("%0t: best_score expected %0d actual %0d", $time, want.best_score,
                   out_data.best_score);
        if (want.copy_second !== out_data.copy_second)
          $display("%0t: copy_second expected %0d actual %0d", $time, want.copy_second,
                   out_data.copy_second);
        if (want.copy_first !== out_data.copy_first)
          $display("%0t: copy_first expected %0d actual %0d", $time, want.copy_first,
                   out_data.copy_first);
        if (want.allele_second !== out_data.allele_second)
          $display("%0t: allele_second expected %0d actual %0d", $time, want.allele_second,
                   out_data.allele_second);
        if (want.allele_first !== out_data.allele_first)
          $display("%0t: allele_first expected %0d actual %0d", $time, want.allele_first,
                   out_data.allele_first);
        if (want !== out_data) failures++;
      end
    end
  end

  // Driver: a beat is held until taken, then a random gap (or none in busy mode).
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        send_gap = send_busy ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall per beat, plus one long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = 300;
    end
    if (out_took) recv_gap = recv_busy ? 0 : $urandom_range(0, 12);
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      if (out_valid && recv_gap > 0) recv_gap--;
      out_stall <= (recv_gap > 0);
    end
  end

  function automatic mcngs_pkg::in_item_t load_beat(mcngs_pkg::op_t op, int row, int col,
                                                    logic [31:0] val);
    mcngs_pkg::in_item_t it;
    it = mcngs_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.operation = op;
    it.prior_row = 3'(row);
    it.prior_col = 3'(col);
    it.prior_value = $signed(val);
    return it;
  endfunction

  function automatic mcngs_pkg::in_item_t eval_beat(int ns, int ts, int rr, int ff);
    mcngs_pkg::in_item_t it;
    it = mcngs_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.operation = mcngs_pkg::OP_EVAL;
    it.normal_step = 7'(ns);
    it.tumor_step = 6'(ts);
    it.ratio_linear = 20'(rr);
    it.allele_fraction = 17'(ff);
    return it;
  endfunction

  // Mostly on-grid evaluates with random content; some loads, idle codes and raw noise.
  function automatic mcngs_pkg::in_item_t random_beat();
    mcngs_pkg::in_item_t it;
    int pick, ns;
    pick = $urandom_range(0, 99);
    ns = $urandom_range(0, 99);
    if (pick < 12) begin
      it = load_beat(($urandom_range(0, 1) == 0) ? mcngs_pkg::OP_LOAD_FWD
                                                 : mcngs_pkg::OP_LOAD_REV,
                     $urandom_range(0, 7), $urandom_range(0, 7),
                     ($urandom_range(0, 9) == 0) ? $urandom
                                                 : 32'($signed($urandom_range(0, 400000)) - 200000));
    end else if (pick < 16) begin
      it = mcngs_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
      it.operation = mcngs_pkg::OP_NONE;
    end else if (pick < 26) begin
      it = eval_beat($urandom_range(0, 127), $urandom_range(0, 63), $urandom, $urandom);
    end else begin
      it = eval_beat(ns, $urandom_range(0, (101 - ns) / 2),
                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000),
                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536));
    end
    return it;
  endfunction

  task automatic write_reg(mcngs_pkg::reg_idx_t idx, logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mcngs_pkg::REG_RATIO_SCALE: scale_shadow = 64'(val);
      mcngs_pkg::REG_ALLELE_CAP:  cap_shadow = int'(val[2:0]);
      mcngs_pkg::REG_COPY_LIMIT:  limit_shadow = int'(val[2:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until everything queued has been sent and answered.
  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_scores.size() > 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic random_phase(int scale, int cap, int lim, int count);
    write_reg(mcngs_pkg::REG_RATIO_SCALE, 20'(scale));
    write_reg(mcngs_pkg::REG_ALLELE_CAP, 20'(cap));
    write_reg(mcngs_pkg::REG_COPY_LIMIT, 20'(lim));
    send_busy = ($urandom_range(0, 3) == 0);
    recv_busy = ($urandom_range(0, 3) == 0);
    repeat (count) pending_beats.push_back(random_beat());
    drain();
  endtask

  initial begin
    int i;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Fill both tables with moderate priors so no evaluate reads an unwritten entry.
    send_busy = 1'b1;
    for (i = 0; i < mcngs_pkg::DEPTH; i++) begin
      pending_beats.push_back(load_beat(mcngs_pkg::OP_LOAD_FWD, i / 8, i % 8,
                              32'($signed($urandom_range(0, 200000)) - 100000)));
      pending_beats.push_back(load_beat(mcngs_pkg::OP_LOAD_REV, i / 8, i % 8,
                              32'($signed($urandom_range(0, 200000)) - 100000)));
    end
    drain();

    // Directed corners at reset settings: triangle edges, off-grid points, field extremes.
    send_busy = 1'b0;
    pending_beats.push_back(eval_beat(0, 0, 0, 0));
    pending_beats.push_back(eval_beat(99, 1, 20'hFFFFF, 65536));
    pending_beats.push_back(eval_beat(0, 50, 131072, 32768));
    pending_beats.push_back(eval_beat(0, 51, 65536, 0));
    pending_beats.push_back(eval_beat(100, 0, 65536, 0));
    pending_beats.push_back(eval_beat(127, 63, 20'hFFFFF, 17'h1FFFF));
    pending_beats.push_back(eval_beat(98, 2, 65536, 17'h1FFFF));
    pending_beats.push_back(load_beat(mcngs_pkg::OP_NONE, 7, 7, 32'hFFFF_FFFF));
    drain();

    // Extreme prior values: the lowest drives the score negative, the highest gives the largest prior sum.
    write_reg(mcngs_pkg::REG_COPY_LIMIT, 20'd0);
    pending_beats.push_back(load_beat(mcngs_pkg::OP_LOAD_FWD, 0, 0, 32'h8000_0000));
    pending_beats.push_back(load_beat(mcngs_pkg::OP_LOAD_REV, 0, 0, 32'h8000_0000));
    pending_beats.push_back(eval_beat(40, 20, 65536, 20000));
    pending_beats.push_back(load_beat(mcngs_pkg::OP_LOAD_FWD, 0, 0, 32'h7FFF_FFFF));
    pending_beats.push_back(load_beat(mcngs_pkg::OP_LOAD_REV, 0, 0, 32'h7FFF_FFFF));
    pending_beats.push_back(eval_beat(40, 20, 20'hFFFFF, 17'h1FFFF));
    pending_beats.push_back(load_beat(mcngs_pkg::OP_LOAD_FWD, 0, 0, 32'd0));
    pending_beats.push_back(load_beat(mcngs_pkg::OP_LOAD_REV, 0, 0, 32'hFFFF_FFFF));
    drain();
    write_reg(mcngs_pkg::REG_UNUSED, 20'hFFFFF);

    // Long receiver hold-off while loads keep arriving, so the input backs up.
    hold_req = 1'b1;
    for (i = 0; i < 40; i++)
      pending_beats.push_back(load_beat(($urandom_range(0, 1) == 0) ? mcngs_pkg::OP_LOAD_FWD
                                                                    : mcngs_pkg::OP_LOAD_REV,
                              $urandom_range(0, 7), $urandom_range(0, 7),
                              32'($signed($urandom_range(0, 200000)) - 100000)));
    drain();

    // Register settings from corner to corner; most searches stay small for speed.
    random_phase(65536, 7, 2, 30);
    random_phase(0, 0, 2, 30);
    random_phase(1048575, 7, 1, 30);
    random_phase(40000, 3, 3, 40);
    random_phase(70000, 1, 0, 30);
    random_phase(65536, 2, 3, 40);
    random_phase($urandom, 7, 7, 3);
    random_phase($urandom_range(30000, 100000), $urandom_range(0, 7), $urandom_range(0, 3), 40);

    repeat (50) @(posedge clk);
    if (failures == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
